/* rtl/core/salts_pkg.sv */
// Package for the set-associative LRU tag store: geometry, field widths,
// configuration register indexes and the sequencer state type.
// No dependencies.
`timescale 1ns / 1ps

package salts_pkg;

  localparam int unsigned Sets      = 256;
  localparam int unsigned Ways      = 8;
  localparam int unsigned AddrWidth = 32;
  localparam int unsigned SetBits   = $clog2(Sets);
  localparam int unsigned WayBits   = $clog2(Ways);
  localparam int unsigned EntryBits = SetBits + WayBits;
  localparam int unsigned StampW    = 32;
  localparam int unsigned CfgW      = 4;
  localparam int unsigned CfgIdxW   = 2;
  localparam int unsigned OutDataW  = 8;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_OFFSET_BITS = 2'd0,
    CFG_INDEX_BITS  = 2'd1,
    CFG_WAYS_IN_USE = 2'd2,
    CFG_UNUSED      = 2'd3
  } cfg_idx_e;

  typedef enum logic [4:0] {
    S_CLEAR = 5'b00001,
    S_IDLE  = 5'b00010,
    S_RD    = 5'b00100,
    S_CMP   = 5'b01000,
    S_WR    = 5'b10000
  } state_e;

  typedef struct packed {
    logic              valid;
    logic [StampW-1:0] stamp;
    logic [AddrWidth-1:0] tag;
  } entry_t;

endpackage

/* rtl/core/set_associative_lru_tag_store.sv */
// Top level of the set-associative LRU tag store: entry memory, way-by-way
// lookup sequencer, victim search and result register.
// Depends on salts_pkg.
`timescale 1ns / 1ps

// Channel      Direction  Payload
// s_axis       in         tdata[31:0] address
// m_axis       out        tdata[0] hit, [1] cold_miss, [4:2] way, [7:5] zero
// cfg          in         cfg_idx_i register index, cfg_data_i 4-bit value
//
// An access makes one memory read and one compare per way examined through the
// single entry memory port, then one write-back.
// A miss examines all ways in use, a hit at way w examines w+1 ways.
// After reset a clearing pass zeroes all 2048 entries of the entry memory; no beat
// is accepted meanwhile, configuration writes are taken as ever.
// Write-back waits while the previous result beat has not been taken.

module set_associative_lru_tag_store (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  input  logic [salts_pkg::AddrWidth-1:0] s_axis_tdata,  // address
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  output logic [salts_pkg::OutDataW-1:0] m_axis_tdata,   // hit, cold_miss, way[2:0]
  input  logic                          cfg_we_i,
  input  logic [salts_pkg::CfgIdxW-1:0] cfg_idx_i,
  input  logic [salts_pkg::CfgW-1:0]    cfg_data_i
);
  import salts_pkg::*;

  state_e               state_q, state_d;
  logic [CfgW-1:0]      off_bits_q, idx_bits_q, ways_q;
  logic [EntryBits-1:0] clr_q, clr_d;
  logic [SetBits-1:0]   set_q, set_d;
  logic [AddrWidth-1:0] tag_q, tag_d;
  logic [WayBits-1:0]   cnt_q, cnt_d;
  logic [WayBits-1:0]   sel_q, sel_d;
  logic [StampW-1:0]    best_q, best_d;
  logic                 vict_valid_q, vict_valid_d;
  logic                 hit_q, hit_d;
  logic [StampW-1:0]    count_q, count_d;
  logic                 out_valid_q, out_valid_d;
  logic                 out_hit_q, out_cold_q;
  logic [WayBits-1:0]   out_way_q;

  entry_t               mem_q [Sets*Ways];
  entry_t               rd_q;
  entry_t               wr_data;
  logic                 mem_we;
  logic [EntryBits-1:0] wr_addr;

  logic [SetBits-1:0]   set_mask;
  logic [4:0]           tag_shift;
  logic [AddrWidth-1:0] addr_sh;
  logic [WayBits-1:0]   last_way;
  logic                 slot_free;
  logic                 wr_fire;
  logic                 in_fire;

  assign s_axis_tready = (state_q == S_IDLE);
  assign in_fire       = s_axis_tvalid && s_axis_tready;
  assign slot_free     = !out_valid_q || m_axis_tready;
  assign wr_fire       = (state_q == S_WR) && slot_free;

  always_comb begin
    if (idx_bits_q >= CfgW'(SetBits)) begin
      set_mask = '1;
    end else begin
      set_mask = SetBits'(({{SetBits{1'b0}}, 1'b1} << idx_bits_q) - 1'b1);
    end
    tag_shift = {1'b0, off_bits_q} + {1'b0, idx_bits_q};
    addr_sh   = s_axis_tdata >> off_bits_q;
    if (ways_q == '0) begin
      last_way = '0;
    end else if (ways_q > CfgW'(Ways)) begin
      last_way = WayBits'(Ways - 1);
    end else begin
      last_way = WayBits'(ways_q - 1'b1);
    end
  end

  always_comb begin
    wr_data = '{valid: 1'b1, stamp: count_q, tag: tag_q};
    wr_addr = {set_q, sel_q};
    mem_we  = wr_fire;
    if (state_q == S_CLEAR) begin
      wr_data = '0;
      wr_addr = clr_q;
      mem_we  = 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[wr_addr] <= wr_data;
    end
    rd_q <= mem_q[{set_q, cnt_q}];
  end

  always_comb begin
    state_d      = state_q;
    clr_d        = clr_q;
    set_d        = set_q;
    tag_d        = tag_q;
    cnt_d        = cnt_q;
    sel_d        = sel_q;
    best_d       = best_q;
    vict_valid_d = vict_valid_q;
    hit_d        = hit_q;
    count_d      = count_q;
    out_valid_d  = out_valid_q && !m_axis_tready;
    case (state_q)
      S_CLEAR: begin
        clr_d = clr_q + 1'b1;
        if (clr_q == '1) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_fire) begin
          set_d   = addr_sh[SetBits-1:0] & set_mask;
          tag_d   = s_axis_tdata >> tag_shift;
          cnt_d   = '0;
          sel_d   = '0;
          hit_d   = 1'b0;
          state_d = S_RD;
        end
      end
      S_RD: begin
        state_d = S_CMP;
      end
      S_CMP: begin
        if (rd_q.valid && (rd_q.tag == tag_q)) begin
          hit_d   = 1'b1;
          sel_d   = cnt_q;
          state_d = S_WR;
        end else begin
          if ((cnt_q == '0) || (rd_q.stamp < best_q)) begin
            best_d       = rd_q.stamp;
            sel_d        = cnt_q;
            vict_valid_d = rd_q.valid;
          end
          if (cnt_q == last_way) begin
            state_d = S_WR;
          end else begin
            cnt_d   = cnt_q + 1'b1;
            state_d = S_RD;
          end
        end
      end
      S_WR: begin
        if (slot_free) begin
          out_valid_d = 1'b1;
          if (count_q != '1) begin
            count_d = count_q + 1'b1;
          end
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLEAR;
      clr_q       <= '0;
      count_q     <= '0;
      out_valid_q <= 1'b0;
      off_bits_q  <= CfgW'(6);
      idx_bits_q  <= CfgW'(8);
      ways_q      <= CfgW'(8);
    end else begin
      state_q     <= state_d;
      clr_q       <= clr_d;
      count_q     <= count_d;
      out_valid_q <= out_valid_d;
      if (cfg_we_i) begin
        case (cfg_idx_e'(cfg_idx_i))
          CFG_OFFSET_BITS: off_bits_q <= cfg_data_i;
          CFG_INDEX_BITS:  idx_bits_q <= cfg_data_i;
          CFG_WAYS_IN_USE: ways_q     <= cfg_data_i;
          default: begin
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    set_q        <= set_d;
    tag_q        <= tag_d;
    cnt_q        <= cnt_d;
    sel_q        <= sel_d;
    best_q       <= best_d;
    vict_valid_q <= vict_valid_d;
    hit_q        <= hit_d;
    if (wr_fire) begin
      out_hit_q  <= hit_q;
      out_cold_q <= !hit_q && !vict_valid_q;
      out_way_q  <= sel_q;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {{(OutDataW-2-WayBits){1'b0}}, out_way_q, out_cold_q, out_hit_q};

  a_count_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    wr_fire |=> (count_q == $past(count_q) + 1'b1) || ($past(count_q) == '1))
    else $error("access count did not advance on write-back");

  a_hit_not_cold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> !(out_hit_q && out_cold_q))
    else $error("result marked both hit and cold miss");

  a_sel_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_WR) |-> (sel_q <= last_way))
    else $error("selected way beyond ways in use");

  a_no_accept_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_CLEAR) |=> !$past(in_fire))
    else $error("beat accepted during clearing pass");

endmodule

/* bench/tb_set_associative_lru_tag_store.sv */
// Self-checking bench for set_associative_lru_tag_store: streams access addresses
// through several cache geometries and checks every hit/miss result beat.
// Depends on salts_pkg and the set_associative_lru_tag_store RTL.
`timescale 1ns / 1ps

module tb_set_associative_lru_tag_store;
  import salts_pkg::*;

  localparam int unsigned NPhases   = 8;
  localparam int unsigned RandItems = 138;

  typedef struct packed {
    logic       hit;
    logic       cold;
    logic [2:0] way;
  } lookup_t;

  logic                 clk_i = 1'b0;
  logic                 rst_ni = 1'b0;
  logic                 s_axis_tvalid = 1'b0;
  logic                 s_axis_tready;
  logic [AddrWidth-1:0] s_axis_tdata = '0;
  logic                 m_axis_tvalid;
  logic                 m_axis_tready = 1'b0;
  logic [OutDataW-1:0]  m_axis_tdata;
  logic                 cfg_we_i = 1'b0;
  logic [CfgIdxW-1:0]   cfg_idx_i = CFG_OFFSET_BITS;
  logic [CfgW-1:0]      cfg_data_i = '0;

  set_associative_lru_tag_store uut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_data_i    (cfg_data_i)
  );

  bit [31:0] line_tag   [Sets*Ways];
  bit        line_valid [Sets*Ways];
  bit [31:0] line_stamp [Sets*Ways];
  bit [31:0] access_cnt = '0;

  int unsigned cfg_offset = 6;
  int unsigned cfg_index  = 8;
  int unsigned cfg_ways   = 8;

  logic [31:0] pending_addrs[$];
  lookup_t     expected_lookups[$];
  logic [31:0] tag_pool[12];
  logic [31:0] set_pool[4];

  int tx_idle_pct = 0;
  int rx_idle_pct = 0;
  int phase_no    = -1;
  logic rx_hold   = 1'b0;

  int fail_cnt = 0;
  int seen_cnt = 0;
  int hit_cnt  = 0;
  int cold_cnt = 0;

  initial begin
    forever #6 clk_i = ~clk_i;
  end

  function automatic int unsigned ways_eff();
    if (cfg_ways == 0) return 1;
    if (cfg_ways > Ways) return Ways;
    return cfg_ways;
  endfunction

  function automatic lookup_t predict_lookup(logic [31:0] addr);
    int unsigned nways, base, sel, w;
    logic [31:0] set_f, tag_v, best;
    bit hit;
    lookup_t r;
    nways = ways_eff();
    set_f = ((addr >> cfg_offset) & ((32'd1 << cfg_index) - 32'd1)) % Sets;
    tag_v = addr >> (cfg_offset + cfg_index);
    base  = set_f * Ways;
    hit   = 1'b0;
    sel   = 0;
    r     = '0;
    for (w = 0; w < nways; w++) begin
      if (!hit && line_valid[base+w] && line_tag[base+w] == tag_v) begin
        hit = 1'b1;
        sel = w;
      end
    end
    if (hit) begin
      line_stamp[base+sel] = access_cnt;
    end else begin
      best = line_stamp[base];
      for (w = 1; w < nways; w++) begin
        if (line_stamp[base+w] < best) begin
          best = line_stamp[base+w];
          sel  = w;
        end
      end
      r.cold = !line_valid[base+sel];
      line_tag[base+sel]   = tag_v;
      line_valid[base+sel] = 1'b1;
      line_stamp[base+sel] = access_cnt;
    end
    if (access_cnt != 32'hFFFF_FFFF) access_cnt++;
    r.hit = hit;
    r.way = sel[2:0];
    return r;
  endfunction

  // Mostly addresses built from a small pool of tags and sets so that lines
  // are reused and evicted; the rest are fully random.
  function automatic logic [31:0] make_address();
    int unsigned pick, top;
    logic [31:0] t, s, o;
    pick = $urandom_range(99);
    if (pick < 12) return $urandom();
    top = (ways_eff() + 3 > 11) ? 11 : ways_eff() + 3;
    t = tag_pool[$urandom_range(top)];
    s = set_pool[$urandom_range(3)] & ((32'd1 << cfg_index) - 32'd1);
    o = $urandom() & ((32'd1 << cfg_offset) - 32'd1);
    return (t << (cfg_offset + cfg_index)) | (s << cfg_offset) | o;
  endfunction

  task automatic report_mismatch(string what, int got, int want);
    $display("MISMATCH at %0t: %s got %0h expected %0h", $realtime, what, got, want);
    fail_cnt++;
  endtask

  task automatic write_reg(cfg_idx_e idx, int unsigned value);
    @(posedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= value[3:0];
    case (idx)
      CFG_OFFSET_BITS: cfg_offset = value;
      CFG_INDEX_BITS:  cfg_index  = value;
      CFG_WAYS_IN_USE: cfg_ways   = value;
      default: ;
    endcase
  endtask

  task automatic wait_drained();
    @(negedge clk_i);
    while (pending_addrs.size() != 0 || s_axis_tvalid || expected_lookups.size() != 0)
      @(negedge clk_i);
  endtask

  always @(posedge clk_i) begin
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
    end else begin
      if (s_axis_tvalid && s_axis_tready) begin
        expected_lookups.push_back(predict_lookup(s_axis_tdata));
      end
      if (!s_axis_tvalid || s_axis_tready) begin
        if (pending_addrs.size() != 0 && $urandom_range(99) >= tx_idle_pct) begin
          s_axis_tvalid <= 1'b1;
          s_axis_tdata  <= pending_addrs.pop_front();
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    lookup_t want;
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        seen_cnt++;
        if (m_axis_tdata[0]) hit_cnt++;
        if (m_axis_tdata[1]) cold_cnt++;
        if (expected_lookups.size() == 0) begin
          report_mismatch("unexpected result beat", int'(m_axis_tdata), 0);
        end else begin
          want = expected_lookups.pop_front();
          if (m_axis_tdata[0] !== want.hit)
            report_mismatch("hit", int'(m_axis_tdata[0]), int'(want.hit));
          if (m_axis_tdata[1] !== want.cold)
            report_mismatch("cold_miss", int'(m_axis_tdata[1]), int'(want.cold));
          if (m_axis_tdata[4:2] !== want.way)
            report_mismatch("way", int'(m_axis_tdata[4:2]), int'(want.way));
          if (m_axis_tdata[7:5] !== 3'b000)
            report_mismatch("pad", int'(m_axis_tdata[7:5]), 0);
        end
      end
      m_axis_tready <= !rx_hold && ($urandom_range(99) >= rx_idle_pct);
    end
  end

  initial begin
    wait (phase_no == 6);
    repeat (30) @(posedge clk_i);
    rx_hold <= 1'b1;
    repeat (400) @(posedge clk_i);
    rx_hold <= 1'b0;
  end

  initial begin
    #6_000_000;
    $display("RESULT: ERROR");
    $finish;
  end

  initial begin
    int unsigned phase_cfg [NPhases][3];
    int i, p;
    phase_cfg = '{'{6, 8, 8}, '{0, 0, 8}, '{12, 8, 1}, '{15, 15, 15},
                  '{4, 10, 4}, '{0, 0, 0}, '{3, 2, 2}, '{12, 0, 8}};
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    for (p = 0; p < NPhases; p++) begin
      write_reg(CFG_OFFSET_BITS, phase_cfg[p][0]);
      write_reg(CFG_INDEX_BITS, phase_cfg[p][1]);
      write_reg(CFG_WAYS_IN_USE, phase_cfg[p][2]);
      @(posedge clk_i);
      cfg_we_i <= 1'b0;
      @(negedge clk_i);
      if (p < 3) begin
        tx_idle_pct = 34;
        rx_idle_pct = 68;
      end else if (p < 6) begin
        tx_idle_pct = 68;
        rx_idle_pct = 34;
      end else begin
        tx_idle_pct = 0;
        rx_idle_pct = 0;
      end
      foreach (tag_pool[k]) tag_pool[k] = $urandom();
      foreach (set_pool[k]) set_pool[k] = $urandom();
      if (p == 0) begin
        pending_addrs = '{32'h0000_0000, 32'h0000_4000, 32'h0000_403F, 32'hFFFF_FFFF,
                          32'hFFFF_FFC0, 32'h0000_8000, 32'h0000_C000, 32'h0001_0000,
                          32'h0001_4000, 32'h0001_8000, 32'h0001_C000, 32'h0002_0000,
                          32'h0002_4000, 32'h0000_4000, 32'h0000_0010};
      end else if (p == 3) begin
        pending_addrs = '{32'h0000_8000, 32'h0080_8000, 32'hC000_0000};
      end
      for (i = 0; i < RandItems; i++) pending_addrs.push_back(make_address());
      phase_no = p;
      wait_drained();
    end
    repeat (40) @(posedge clk_i);
    $display("Checked %0d lookups (%0d hits, %0d cold misses) across %0d cache geometries,",
             seen_cnt, hit_cnt, cold_cnt, NPhases);
    $display("including direct-mapped, fully associative, index wrap and a long output stall.");
    if (fail_cnt == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
